// ----- hdl/pib_pkg.sv -----
// Package: constants and pipeline item type for the polynomial inverse block.
package pib_pkg;
  localparam int STEPS     = 24;
  localparam int FRAC_BITS = 16;
  localparam int XW        = 7 + FRAC_BITS;
  localparam int NCOEF     = 6;
  localparam int MVW       = 13;
  localparam int PW        = 23;
  localparam int AW        = 6;
  localparam int DW        = 64;
  localparam int PPW       = 32 + XW;

  localparam logic [XW-1:0] X_MAX = XW'(100) << FRAC_BITS;

  localparam logic [DW-1:0] COEF_RST [NCOEF] = '{
    64'sd169586474444915,
    64'sd70324433859065,
    -64'sd3050540035683,
    64'sd100426863204,
    -64'sd1243162822,
    64'sd5067617
  };

  typedef logic [NCOEF-1:0][DW-1:0] pib_coefs_t;

  typedef struct packed {
    logic           vld;
    logic           bad;
    logic [MVW-1:0] mv;
    logic [XW-1:0]  lo;
    logic [XW-1:0]  hi;
    logic [XW-1:0]  mid;
    logic [DW-1:0]  acc;
  } pib_item_t;
endpackage

// ----- hdl/pib_if.sv -----
// Valid/ready channel interfaces for readings and results.
interface pib_in_if;
  logic                     valid;
  logic                     ready;
  logic [pib_pkg::MVW-1:0]  millivolts;
  modport source (output valid, output millivolts, input ready);
  modport sink (input valid, input millivolts, output ready);
endinterface

interface pib_out_if;
  logic                    valid;
  logic                    ready;
  logic [pib_pkg::PW-1:0]  percent;
  modport source (output valid, output percent, input ready);
  modport sink (input valid, input percent, output ready);
endinterface

// ----- hdl/pib_cfg.sv -----
// APB coefficient register file.
module pib_cfg
  import pib_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [AW-1:0] cfg_paddr,
  input  logic [DW-1:0] cfg_pwdata,
  output logic [DW-1:0] cfg_prdata,
  output logic          cfg_pready,
  output pib_coefs_t    coefs
);
  pib_coefs_t coef_r;
  logic [2:0] idx;

  assign idx        = cfg_paddr[AW-1:3];
  assign cfg_pready = 1'b1;
  assign coefs      = coef_r;

  always_comb begin
    cfg_prdata = '0;
    if (idx < 3'(NCOEF)) begin
      cfg_prdata = coef_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) coef_r[i] <= COEF_RST[i];
    end else if (cfg_psel && cfg_penable && cfg_pwrite && idx < 3'(NCOEF)) begin
      coef_r[idx] <= cfg_pwdata;
    end
  end
endmodule

// ----- hdl/pib_horner.sv -----
// One Horner step: split multiply stage, then scale, saturate and add stage.
module pib_horner
  import pib_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [DW-1:0] coef,
  input  pib_item_t     item_i,
  output pib_item_t     item_o
);
  pib_item_t      a_r;
  logic           neg_r;
  logic [PPW-1:0] plo_r, phi_r;
  pib_item_t      b_r;

  logic          neg;
  logic [DW-1:0] mag;

  logic [DW+XW-1:0] full, q;
  logic [DW-1:0]    lim, qs, prod, sum;

  assign neg = item_i.acc[DW-1];
  assign mag = neg ? DW'(0) - item_i.acc : item_i.acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
      b_r.vld <= 1'b0;
    end else if (en) begin
      a_r.vld <= item_i.vld;
      b_r.vld <= a_r.vld;
    end
    if (en) begin
      {a_r.bad, a_r.mv, a_r.lo, a_r.hi, a_r.mid, a_r.acc} <=
        {item_i.bad, item_i.mv, item_i.lo, item_i.hi, item_i.mid, item_i.acc};
      neg_r <= neg;
      plo_r <= PPW'(mag[31:0]) * PPW'(item_i.mid);
      phi_r <= PPW'(mag[63:32]) * PPW'(item_i.mid);
      {b_r.bad, b_r.mv, b_r.lo, b_r.hi, b_r.mid} <=
        {a_r.bad, a_r.mv, a_r.lo, a_r.hi, a_r.mid};
      b_r.acc <= sum;
    end
  end

  always_comb begin
    full = ((DW+XW)'(phi_r) << 32) + (DW+XW)'(plo_r);
    q    = full >> FRAC_BITS;
    lim  = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    qs   = (q > (DW+XW)'(lim)) ? lim : q[DW-1:0];
    prod = neg_r ? DW'(0) - qs : qs;
    sum  = prod + coef;
    if (prod[DW-1] == coef[DW-1] && sum[DW-1] != prod[DW-1]) begin
      sum = prod[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign item_o = b_r;
endmodule

// ----- hdl/pib_step.sv -----
// One bisection step: midpoint, five Horner steps, compare and bound update.
module pib_step
  import pib_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  pib_coefs_t coefs,
  input  pib_item_t  item_i,
  output pib_item_t  item_o
);
  pib_item_t   ent_r, fin_r;
  pib_item_t   chain [NCOEF];
  logic [XW:0] s;
  logic [DW-1:0] tgt;
  logic        below;

  assign s = {1'b0, item_i.lo} + {1'b0, item_i.hi};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
      fin_r.vld <= 1'b0;
    end else if (en) begin
      ent_r.vld <= item_i.vld;
      fin_r.vld <= chain[0].vld;
    end
    if (en) begin
      {ent_r.bad, ent_r.mv, ent_r.lo, ent_r.hi} <=
        {item_i.bad, item_i.mv, item_i.lo, item_i.hi};
      ent_r.mid <= s[XW:1];
      ent_r.acc <= coefs[NCOEF-1];
      {fin_r.bad, fin_r.mv, fin_r.mid, fin_r.acc} <=
        {chain[0].bad, chain[0].mv, chain[0].mid, chain[0].acc};
      fin_r.lo <= below ? chain[0].mid : chain[0].lo;
      fin_r.hi <= below ? chain[0].hi : chain[0].mid;
    end
  end

  assign chain[NCOEF-1] = ent_r;

  for (genvar k = 0; k < NCOEF - 1; k++) begin : g_horner
    pib_horner u_horner (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .coef   (coefs[k]),
      .item_i (chain[k+1]),
      .item_o (chain[k])
    );
  end

  assign tgt   = {(DW-MVW-40)'(0), chain[0].mv, 40'd0};
  assign below = $signed(chain[0].acc) < $signed(tgt);

  assign item_o = fin_r;
endmodule

// ----- hdl/poly_inverse_bisection.sv -----
// Top level: reading-to-percent inverter of a fifth-degree curve by bisection.
// Readings enter on in_ch (valid/ready, millivolts, 13-bit signed); each
// transaction gives exactly one result on out_ch (percent, unsigned Q7.16).
// A negative reading gives 0 percent.
// Coefficients coef0..coef5 are 64-bit signed Q24.40 registers on the APB
// port at byte addresses 0, 8, .. 40; the user must see that they are written
// only while idle, as the block does not enforce it. Throughput: one reading
// per cycle unless out_ch stalls; 24 bisection steps of 12 register stages
// each (midpoint, five 2-stage Horner steps, compare) and an output register.
// The whole pipeline advances together; when the receiver holds out_ch.ready
// low with a result waiting, every stage holds and in_ch.ready drops, so no
// transaction is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// sensor curve into the coefficient registers.
module poly_inverse_bisection
  import pib_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  pib_in_if.sink        in_ch,
  pib_out_if.source     out_ch,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [AW-1:0] cfg_paddr,
  input  logic [DW-1:0] cfg_pwdata,
  output logic [DW-1:0] cfg_prdata,
  output logic          cfg_pready
);
  localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  pib_coefs_t    coefs;
  pib_item_t     stage [STEPS+1];
  logic          en;
  logic          out_vld_r;
  logic [PW-1:0] pct_r, pct_nxt;
  logic [XW:0]   s;
  logic [XW+16:0] p;

  pib_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .coefs       (coefs)
  );

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    stage[0].vld = in_ch.valid;
    stage[0].bad = in_ch.millivolts[MVW-1];
    stage[0].mv  = in_ch.millivolts;
    stage[0].lo  = '0;
    stage[0].hi  = X_MAX;
    stage[0].mid = '0;
    stage[0].acc = '0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    pib_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .coefs  (coefs),
      .item_i (stage[i]),
      .item_o (stage[i+1])
    );
  end

  always_comb begin
    s = {1'b0, stage[STEPS].lo} + {1'b0, stage[STEPS].hi};
    p = ((XW+17)'(s[XW:1]) >> SHR) << SHL;
    pct_nxt = stage[STEPS].bad ? '0 : p[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= stage[STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pct_r <= pct_nxt;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.percent = pct_r;
endmodule
